// ----- rtl/core/rgb_text_spec_parser_macros.svh -----
// ----------------------------------------------------------------------------
// RGB text spec parser assertion macros
// Shared concurrent assertion wrappers for the parser checker.
// ----------------------------------------------------------------------------
`ifndef RGB_TEXT_SPEC_PARSER_MACROS_SVH
`define RGB_TEXT_SPEC_PARSER_MACROS_SVH

// Assertion that is switched off while reset is asserted.
`define RGB_TSP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is also checked during reset.
`define RGB_TSP_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/rgb_tsp_pkg.sv -----
// ----------------------------------------------------------------------------
// RGB text spec parser package
// Parser state, result types and character codes shared by the parser.
// ----------------------------------------------------------------------------
package rgb_tsp_pkg;

    // Character codes recognized by the parser.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Scan phase of the current spec.
    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_DIGITS = 3'd1,
        PH_REST   = 3'd2,
        PH_AFTER  = 3'd3,
        PH_DONE   = 3'd4,
        PH_DRAIN  = 3'd5
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  idx;
        logic [8:0]  acc;
        logic        pct;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        failed;
    } parse_state_t;

    typedef struct packed {
        logic        emit;
        logic        ok;
        logic [23:0] colour;
    } step_res_t;

    localparam parse_state_t STATE_CLEAR = '{
        phase:  PH_LEAD,
        idx:    2'd0,
        acc:    9'd0,
        pct:    1'b0,
        red:    8'd0,
        green:  8'd0,
        blue:   8'd0,
        failed: 1'b0
    };

endpackage

// ----- rtl/core/rgb_tsp_step.sv -----
// ----------------------------------------------------------------------------
// RGB text spec parser step logic
// Combinational update of the parser state for one character.
// ----------------------------------------------------------------------------
module rgb_tsp_step
    import rgb_tsp_pkg::*;
(
    input  parse_state_t state_cur,
    input  logic [7:0]   text_byte,
    input  logic         end_of_spec,
    output parse_state_t state_next,
    output step_res_t    res
);

    // Commits the open token into the next colour slot.
    function automatic parse_state_t commit_tok(input parse_state_t s);
        parse_state_t r;
        logic [6:0]   v;
        logic [14:0]  x;
        logic [27:0]  p;
        logic [7:0]   val;
        r = s;
        if (s.pct) begin
            v = (s.acc > 9'd100) ? 7'd100 : s.acc[6:0];
            // v * 255 / 100, the division done as a multiply by 2^19 / 100.
            x = ({8'd0, v} << 8) - {8'd0, v};
            p = {13'd0, x} * 28'd5243;
            val = p[26:19];
        end else begin
            val = (s.acc > 9'd255) ? 8'd255 : s.acc[7:0];
        end
        case (s.idx)
            2'd0: begin
                r.red = val;
            end
            2'd1: begin
                r.green = val;
            end
            default: begin
                r.blue = val;
            end
        endcase
        r.idx = s.idx + 2'd1;
        r.acc = 9'd0;
        r.pct = 1'b0;
        return r;
    endfunction

    function automatic parse_state_t token_end(input parse_state_t s, input logic comma);
        parse_state_t r;
        r = commit_tok(s);
        if (r.idx == 2'd3) begin
            r.phase = PH_DONE;
        end else begin
            r.phase = comma ? PH_LEAD : PH_AFTER;
        end
        return r;
    endfunction

    function automatic parse_state_t consume(input parse_state_t s, input logic [7:0] c);
        parse_state_t r;
        logic         digit;
        logic [12:0]  a;
        r = s;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        a = ({4'd0, s.acc} << 3) + ({4'd0, s.acc} << 1) + {9'd0, c[3:0]};
        case (s.phase)
            PH_LEAD: begin
                if (c != CH_SPACE) begin
                    if (digit) begin
                        r.acc = {5'd0, c[3:0]};
                        r.pct = 1'b0;
                        r.phase = PH_DIGITS;
                    end else begin
                        r.failed = 1'b1;
                        r.phase = PH_DONE;
                    end
                end
            end
            PH_DIGITS: begin
                if (digit) begin
                    r.acc = (a > 13'd511) ? 9'd511 : a[8:0];
                end else if (c == CH_PCT) begin
                    r.pct = 1'b1;
                    r.phase = PH_REST;
                end else if (c == CH_SPACE) begin
                    r = token_end(s, 1'b0);
                end else if (c == CH_COMMA) begin
                    r = token_end(s, 1'b1);
                end else begin
                    r.phase = PH_REST;
                end
            end
            PH_REST: begin
                if (c == CH_SPACE) begin
                    r = token_end(s, 1'b0);
                end else if (c == CH_COMMA) begin
                    r = token_end(s, 1'b1);
                end
            end
            PH_AFTER: begin
                if (c == CH_COMMA) begin
                    r.phase = PH_LEAD;
                end else if (c != CH_SPACE) begin
                    r.failed = 1'b1;
                    r.phase = PH_DONE;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Closes any open token and forms the result fields.
    function automatic step_res_t finish(input parse_state_t s);
        parse_state_t f;
        step_res_t    r;
        f = s;
        if (s.phase == PH_DIGITS || s.phase == PH_REST) begin
            f = token_end(s, 1'b0);
        end
        r.emit = 1'b1;
        r.ok = !f.failed && (f.idx == 2'd3);
        r.colour = r.ok ? {f.red, f.green, f.blue} : 24'd0;
        return r;
    endfunction

    parse_state_t consumed;
    logic         draining;

    assign consumed = consume(state_cur, text_byte);
    assign draining = (state_cur.phase != PH_LEAD) && (state_cur.phase != PH_DIGITS) &&
                      (state_cur.phase != PH_REST) && (state_cur.phase != PH_AFTER) &&
                      (state_cur.phase != PH_DONE);

    always_comb begin
        res = '0;
        state_next = state_cur;
        if (draining) begin
            if (end_of_spec) begin
                state_next = STATE_CLEAR;
            end
        end else if (text_byte == CH_NUL) begin
            res = finish(state_cur);
            state_next = STATE_CLEAR;
            if (!end_of_spec) begin
                state_next.phase = PH_DRAIN;
            end
        end else if (end_of_spec) begin
            res = finish(consumed);
            state_next = STATE_CLEAR;
        end else begin
            state_next = consumed;
        end
    end

endmodule

// ----- rtl/core/rgb_text_spec_parser.sv -----
// ----------------------------------------------------------------------------
// RGB text spec parser
// Parses a colour text spec such as "255, 128, 50%" one byte per request and
// returns one result per spec: an ok flag and the packed 24-bit colour.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                   Direction  Moves
//  --------  --------------------------------------  ---------  ---------------------
//  s_        s_valid s_ready s_text_byte              in         one character per
//            s_end_of_spec                                       request
//  m_        m_valid m_ready m_parse_ok               out        one result per spec
//            m_packed_colour
//
//  A request is taken into an input register and parsed from there; a character
//  that closes a spec loads the result register as it is parsed. One character
//  is accepted per cycle while the input register is free or being parsed; a
//  spec-closing character waits while the previous result has not been taken,
//  and later characters wait behind it. Reset is synchronous, active low, and
//  leaves the parser at the start of a spec.
//
module rgb_text_spec_parser
    import rgb_tsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    input  logic        s_end_of_spec,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_parse_ok,
    output logic [23:0] m_packed_colour
);

    // Input register: holds one accepted character until it is parsed.
    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;

    // Parser state carried from one character to the next.
    parse_state_t state_reg;
    parse_state_t state_next;

    // Result register.
    logic         out_valid_reg;
    logic         out_ok_reg;
    logic [23:0]  out_colour_reg;

    step_res_t    step_res;
    logic         advance;

    rgb_tsp_step u_step (
        .state_cur   (state_reg),
        .text_byte   (in_byte_reg),
        .end_of_spec (in_last_reg),
        .state_next  (state_next),
        .res         (step_res)
    );

    // The held character is parsed unless it produces a result and the
    // result register is still occupied by one that has not been taken.
    assign advance = in_valid_reg && (!step_res.emit || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_text_byte;
            in_last_reg <= s_end_of_spec;
        end
    end

    // The parser state only moves when a character is actually parsed, so
    // a stalled character is seen against the same state on every retry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_CLEAR;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && step_res.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && step_res.emit) begin
            out_ok_reg     <= step_res.ok;
            out_colour_reg <= step_res.colour;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_parse_ok      = out_ok_reg;
    assign m_packed_colour = out_colour_reg;

endmodule

// ----- rtl/core/rgb_tsp_checker.sv -----
// ----------------------------------------------------------------------------
// RGB text spec parser checker
// Port-level assertions on the parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "rgb_text_spec_parser_macros.svh"

module rgb_tsp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_text_byte,
    input logic        s_end_of_spec,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_parse_ok,
    input logic [23:0] m_packed_colour
);

    // A failed spec always reports a black colour.
    `RGB_TSP_ASSERT(a_fail_is_zero, aclk, aresetn, m_valid && !m_parse_ok |-> m_packed_colour == 24'd0, "failed spec with nonzero colour")

    // A waiting result holds its value until taken.
    `RGB_TSP_ASSERT(a_result_holds, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_parse_ok) && $stable(m_packed_colour), "result changed while stalled")

    // Reset leaves no result pending and the input side open.
    `RGB_TSP_ASSERT_RST(a_reset_state, aclk, !aresetn |=> !m_valid && s_ready, "bad state after reset")

    // The input side is never held off while no result is pending.
    `RGB_TSP_ASSERT(a_no_result_no_stall, aclk, aresetn, !m_valid |-> s_ready, "input stalled with empty result register")

endmodule

bind rgb_text_spec_parser rgb_tsp_checker u_rgb_tsp_checker (.*);
